// ----- design/cstp_pkg.sv -----
package cstp_pkg;

  localparam int STACK_DEPTH_DEF = 1024;
  localparam int TABLE_SLOTS_DEF = 1024;

  localparam logic [29:0] NSEC_MAX = 30'd999999999;
  localparam logic [31:0] SEC_MAX  = 32'hFFFF_FFFF;

  localparam logic [1:0] FUNC_ENTER = 2'd0;
  localparam logic [1:0] FUNC_LEAVE = 2'd1;
  localparam logic [1:0] FUNC_CLEAR = 2'd2;

  localparam logic [2:0] ST_PUSHED  = 3'd0;
  localparam logic [2:0] ST_FULL    = 3'd1;
  localparam logic [2:0] ST_EMPTY   = 3'd2;
  localparam logic [2:0] ST_MISMAT  = 3'd3;
  localparam logic [2:0] ST_ACCUM   = 3'd4;
  localparam logic [2:0] ST_REFUSED = 3'd5;
  localparam logic [2:0] ST_CLEARED = 3'd6;

  typedef struct packed {
    logic [1:0]  func;
    logic [63:0] method_id;
    logic [31:0] stamp_sec;
    logic [29:0] stamp_nsec;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] total_sec;
    logic [29:0] total_nsec;
    logic [10:0] depth;
  } rsp_t;

  // controller -> datapath
  typedef struct packed {
    logic load_req;   // capture the incoming request
    logic push;       // write the frame at the stack top
    logic pop_rd;     // decrement top and read the frame below it
    logic probe_rd;   // read the slot at the probe index
    logic probe_next; // advance the probe index
    logic insert;     // count a new key; its slot is written with the total
    logic accum;      // compute the new total
    logic wr_total;   // write the total back
    logic clear_step; // zero one slot's totals, keep its key, and advance the sweep
    logic clear_start;
    logic init_step;  // reset sweep of the table
    logic set_status;
    logic [2:0] status;
    logic emit;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic [1:0] func;
    logic stack_full;
    logic stack_empty;
    logic id_match;
    logic id_null;
    logic key_hit;
    logic key_empty;
    logic table_full;
    logic sweep_last;
    logic probe_wrap;
  } stat_t;

endpackage

// ----- design/cstp_ram.sv -----
module cstp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- design/cstp_ctrl.sv -----
module cstp_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  input  logic            out_free,
  input  cstp_pkg::stat_t st,
  output cstp_pkg::cmd_t  cmd
);

  localparam logic [3:0] S_INIT   = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_DEC    = 4'd2;
  localparam logic [3:0] S_POPW   = 4'd3;
  localparam logic [3:0] S_CMP    = 4'd4;
  localparam logic [3:0] S_PRBW   = 4'd5;
  localparam logic [3:0] S_PRB    = 4'd6;
  localparam logic [3:0] S_ACC    = 4'd7;
  localparam logic [3:0] S_WR     = 4'd8;
  localparam logic [3:0] S_CLR    = 4'd9;
  localparam logic [3:0] S_OUT    = 4'd10;

  logic [3:0] state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
    end else begin
      state <= state_next;
    end
  end

  assign in_stall = (state != S_IDLE);

  always_comb begin
    cmd = '0;
    state_next = state;
    unique case (state)
      S_INIT: begin
        cmd.init_step = 1'b1;
        if (st.sweep_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_req = 1'b1;
          state_next = S_DEC;
        end
      end
      S_DEC: begin
        cmd.set_status = 1'b1;
        priority if (st.func[1]) begin
          cmd.status = cstp_pkg::ST_CLEARED;
          cmd.clear_start = 1'b1;
          state_next = S_CLR;
        end else if (st.func == cstp_pkg::FUNC_ENTER) begin
          if (st.stack_full) begin
            cmd.status = cstp_pkg::ST_FULL;
          end else begin
            cmd.status = cstp_pkg::ST_PUSHED;
            cmd.push = 1'b1;
          end
          state_next = S_OUT;
        end else if (st.stack_empty) begin
          cmd.status = cstp_pkg::ST_EMPTY;
          state_next = S_OUT;
        end else begin
          cmd.status = cstp_pkg::ST_MISMAT;
          cmd.pop_rd = 1'b1;
          state_next = S_POPW;
        end
      end
      S_POPW: state_next = S_CMP;
      S_CMP: begin
        priority if (!st.id_match) begin
          state_next = S_OUT;
        end else if (st.id_null) begin
          cmd.set_status = 1'b1;
          cmd.status = cstp_pkg::ST_REFUSED;
          state_next = S_OUT;
        end else begin
          cmd.probe_rd = 1'b1;
          state_next = S_PRBW;
        end
      end
      S_PRBW: state_next = S_PRB;
      S_PRB: begin
        priority if (st.key_hit) begin
          state_next = S_ACC;
        end else if (st.key_empty) begin
          if (st.table_full) begin
            cmd.set_status = 1'b1;
            cmd.status = cstp_pkg::ST_REFUSED;
            state_next = S_OUT;
          end else begin
            cmd.insert = 1'b1;
            state_next = S_ACC;
          end
        end else if (st.probe_wrap) begin
          cmd.set_status = 1'b1;
          cmd.status = cstp_pkg::ST_REFUSED;
          state_next = S_OUT;
        end else begin
          cmd.probe_next = 1'b1;
          state_next = S_PRBW;
        end
      end
      S_ACC: begin
        cmd.accum = 1'b1;
        state_next = S_WR;
      end
      S_WR: begin
        cmd.wr_total = 1'b1;
        cmd.set_status = 1'b1;
        cmd.status = cstp_pkg::ST_ACCUM;
        state_next = S_OUT;
      end
      S_CLR: begin
        cmd.clear_step = 1'b1;
        if (st.sweep_last) state_next = S_OUT;
      end
      S_OUT: begin
        if (out_free) begin
          cmd.emit = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_INIT;
    endcase
  end

endmodule

// ----- design/cstp_dp.sv -----
module cstp_dp #(
  parameter int STACK_DEPTH = cstp_pkg::STACK_DEPTH_DEF,
  parameter int TABLE_SLOTS = cstp_pkg::TABLE_SLOTS_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  cstp_pkg::req_t  req_in,
  input  cstp_pkg::cmd_t  cmd,
  output cstp_pkg::stat_t st,
  output cstp_pkg::rsp_t  rsp
);

  localparam int SAW = $clog2(STACK_DEPTH);
  localparam int TAW = $clog2(TABLE_SLOTS);
  localparam int FW  = 64 + 32 + 30;
  localparam int SW  = 64 + 32 + 30;

  cstp_pkg::req_t req;
  cstp_pkg::req_t req_clamp;
  logic [SAW:0]   top;
  logic [TAW:0]   used;
  logic [TAW-1:0] idx, idx_start, sweep;
  logic [2:0]     status;
  logic [31:0]    tot_sec;
  logic [29:0]    tot_nsec;
  logic [31:0]    new_sec;
  logic [29:0]    new_nsec;
  logic [FW-1:0]  frame;
  logic [SW-1:0]  slot;
  logic [63:0]    slot_key_q;
  logic [63:0]    rot;

  // frame: {method, sec, nsec}
  logic [63:0] fr_method;
  logic [31:0] fr_sec;
  logic [29:0] fr_nsec;
  assign {fr_method, fr_sec, fr_nsec} = frame;

  logic [63:0] sl_key;
  logic [31:0] sl_sec;
  logic [29:0] sl_nsec;
  assign {sl_key, sl_sec, sl_nsec} = slot;

  // hold the read on the popped frame until the next request
  logic st_we;
  logic [SAW-1:0] st_addr;
  assign st_we   = cmd.push;
  assign st_addr = cmd.pop_rd ? (top[SAW-1:0] - 1'b1) : top[SAW-1:0];

  cstp_ram #(.WIDTH(FW), .DEPTH(STACK_DEPTH)) u_stack (
    .clk   (clk),
    .we    (st_we),
    .waddr (top[SAW-1:0]),
    .wdata ({req.method_id, req.stamp_sec, req.stamp_nsec}),
    .raddr (st_addr),
    .rdata (frame)
  );

  logic           tb_we;
  logic [TAW-1:0] tb_waddr;
  logic [SW-1:0]  tb_wdata;

  always_comb begin
    tb_we    = 1'b0;
    tb_waddr = idx;
    tb_wdata = {slot_key_q, new_sec, new_nsec};
    if (cmd.init_step) begin
      tb_we = 1'b1;
      tb_waddr = sweep;
      tb_wdata = '0;
    end else if (cmd.clear_step) begin
      // keep the key, zero the totals: key is re-read one step ahead
      tb_we = 1'b1;
      tb_waddr = sweep - 1'b1;
      tb_wdata = {sl_key, 62'd0};
    end else if (cmd.wr_total) begin
      tb_we = 1'b1;
    end
  end

  logic [TAW-1:0] tb_raddr;
  assign tb_raddr = (cmd.clear_start || cmd.clear_step) ? sweep : idx;

  cstp_ram #(.WIDTH(SW), .DEPTH(TABLE_SLOTS)) u_table (
    .clk   (clk),
    .we    (tb_we),
    .waddr (tb_waddr),
    .wdata (tb_wdata),
    .raddr (tb_raddr),
    .rdata (slot)
  );

  assign rot       = {req.method_id[7:0], req.method_id[63:8]};
  assign idx_start = rot[TAW-1:0];

  // Elapsed plus previous total, normalised and clamped.
  logic signed [31:0] ns_sum;
  logic signed [34:0] sc_sum;
  logic signed [31:0] ns_adj;
  logic signed [34:0] sc_adj;
  logic [31:0] base_sec;
  logic [29:0] base_nsec;
  logic        fresh;

  assign base_sec  = fresh ? 32'd0 : sl_sec;
  assign base_nsec = fresh ? 30'd0 : sl_nsec;
  assign ns_sum = $signed({2'b00, base_nsec}) + $signed({2'b00, req.stamp_nsec})
                - $signed({2'b00, fr_nsec});
  assign sc_sum = $signed({3'b000, base_sec}) + $signed({3'b000, req.stamp_sec})
                - $signed({3'b000, fr_sec});

  always_comb begin
    ns_adj = ns_sum;
    sc_adj = sc_sum;
    if (ns_sum < 0) begin
      ns_adj = ns_sum + 32'sd1000000000;
      sc_adj = sc_sum - 35'sd1;
    end else if (ns_sum >= 32'sd1000000000) begin
      ns_adj = ns_sum - 32'sd1000000000;
      sc_adj = sc_sum + 35'sd1;
    end
  end

  // saturate out-of-range nanoseconds on arrival
  always_comb begin
    req_clamp = req_in;
    if (req_in.stamp_nsec > cstp_pkg::NSEC_MAX) req_clamp.stamp_nsec = cstp_pkg::NSEC_MAX;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      top    <= '0;
      used   <= '0;
      sweep  <= '0;
      status <= '0;
    end else begin
      // the last clear step writes slot TABLE_SLOTS-1 and leaves the sweep at zero
      if (cmd.init_step || cmd.clear_start || (cmd.clear_step && sweep != '0)) begin
        sweep <= sweep + 1'b1;
      end
      if (cmd.push) top <= top + 1'b1;
      if (cmd.pop_rd) top <= top - 1'b1;
      if (cmd.insert) used <= used + 1'b1;
      if (cmd.set_status) status <= cmd.status;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      req      <= req_clamp;
      tot_sec  <= '0;
      tot_nsec <= '0;
    end
    if (cmd.probe_rd) idx <= idx_start;
    if (cmd.probe_next) idx <= idx + 1'b1;
    if (cmd.probe_rd) fresh <= 1'b0;
    if (cmd.insert) begin
      fresh <= 1'b1;
      slot_key_q <= req.method_id;
    end else if (cmd.probe_rd) begin
      slot_key_q <= req.method_id;
    end
    if (cmd.accum) begin
      priority if (sc_adj < 0) begin
        new_sec  <= '0;
        new_nsec <= '0;
      end else if (sc_adj > $signed({3'b000, cstp_pkg::SEC_MAX})) begin
        new_sec  <= cstp_pkg::SEC_MAX;
        new_nsec <= cstp_pkg::NSEC_MAX;
      end else begin
        new_sec  <= sc_adj[31:0];
        new_nsec <= ns_adj[29:0];
      end
    end
    if (cmd.wr_total) begin
      tot_sec  <= new_sec;
      tot_nsec <= new_nsec;
    end
  end

  // probe start index, to detect a full circle
  logic [TAW-1:0] idx_first;
  always_ff @(posedge clk) begin
    if (cmd.probe_rd) idx_first <= idx_start;
  end

  assign st.func        = req.func;
  assign st.stack_full  = (top >= (SAW+1)'(STACK_DEPTH));
  assign st.stack_empty = (top == '0);
  assign st.id_match    = (fr_method == req.method_id);
  assign st.id_null     = (req.method_id == '0);
  assign st.key_hit     = (sl_key == req.method_id);
  assign st.key_empty   = (sl_key == '0);
  assign st.table_full  = ({used, 1'b0} >= (TAW+2)'(TABLE_SLOTS));
  assign st.sweep_last  = cmd.clear_step ? (sweep == '0) : (sweep == {TAW{1'b1}});
  assign st.probe_wrap  = ((idx + 1'b1) == idx_first);

  assign rsp.status     = status;
  assign rsp.total_sec  = tot_sec;
  assign rsp.total_nsec = tot_nsec;
  assign rsp.depth      = 11'(top);

endmodule

// ----- design/call_stack_time_profiler.sv -----
// channel   direction  payload            handshake
// req       in         cstp_pkg::req_t    req_valid / req_stall
// rsp       out        cstp_pkg::rsp_t    rsp_valid / rsp_stall
//
// One request at a time. Enter and leave on an empty stack go straight to the
// result; leave with mismatch or null id first reads the popped frame; leave
// with lookup probes the table (one table read per probe), as does a refused
// insert. Clear sweeps the table one slot a cycle.
// After reset a sweep zeroes the table; req is stalled meanwhile.
// The result register holds while rsp_stall is high; the next result is
// emitted only once the previous one has gone.
module call_stack_time_profiler #(
  parameter int STACK_DEPTH = cstp_pkg::STACK_DEPTH_DEF,
  parameter int TABLE_SLOTS = cstp_pkg::TABLE_SLOTS_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_stall,
  input  cstp_pkg::req_t req,
  output logic           rsp_valid,
  input  logic           rsp_stall,
  output cstp_pkg::rsp_t rsp
);

  cstp_pkg::cmd_t  cmd;
  cstp_pkg::stat_t st;
  cstp_pkg::rsp_t  rsp_dp;
  logic            out_free;

  assign out_free = !rsp_valid || !rsp_stall;

  cstp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req_valid),
    .in_stall (req_stall),
    .out_free (out_free),
    .st       (st),
    .cmd      (cmd)
  );

  cstp_dp #(.STACK_DEPTH(STACK_DEPTH), .TABLE_SLOTS(TABLE_SLOTS)) u_dp (
    .clk    (clk),
    .rst    (rst),
    .req_in (req),
    .cmd    (cmd),
    .st     (st),
    .rsp    (rsp_dp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.emit) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) rsp <= rsp_dp;
  end

endmodule

// ----- design/cstp_checker.sv -----
module cstp_checker (
  input logic           clk,
  input logic           rst,
  input logic           req_valid,
  input logic           req_stall,
  input cstp_pkg::req_t req,
  input logic           rsp_valid,
  input logic           rsp_stall,
  input cstp_pkg::rsp_t rsp
);

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
    else $error("result changed while stalled");

  a_no_take_after: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall |=> req_stall)
    else $error("request taken back to back");

  a_status_range: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> rsp.status <= cstp_pkg::ST_CLEARED)
    else $error("bad status");

  a_total_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status != cstp_pkg::ST_ACCUM |-> rsp.total_sec == '0
      && rsp.total_nsec == '0)
    else $error("total without accumulate");

endmodule

bind call_stack_time_profiler cstp_checker u_cstp_checker (.*);
